FILE: src/sha1s_pkg.sv
// sha1s_pkg: shared types, constants and round helpers for the sha-1 stream hasher
// used by sha1s_window, sha1s_round and sha1_stream_hasher_core; no dependencies
package sha1s_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0][31:0] words5_t;

    localparam word_t K0 = 32'h5a827999;
    localparam word_t K1 = 32'h6ed9eba1;
    localparam word_t K2 = 32'h8f1bbcdc;
    localparam word_t K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_FILL = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [2:0] LAST_INDEX = 3'd4;

    // chaining value after reset, index 0 is word a
    localparam words5_t INIT_CHAIN = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                      32'hefcdab89, 32'h67452301};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       shift_byte;
        logic       shift_word;
        logic [7:0] byte_in;
    } win_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } rnd_ctl_t;

    function automatic word_t rotl1(input word_t x);
        return {x[30:0], x[31]};
    endfunction

    function automatic word_t rotl5(input word_t x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rotl30(input word_t x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

FILE: src/sha1_stream_hasher_core.sv
// sha1_stream_hasher_core: top level of the byte-stream sha-1 hasher
// sequencer, chaining value, byte count and digest output; uses sha1s_pkg,
// sha1s_window and sha1s_round
//
// usage:
// - input channel (in_valid / in_stall) takes one beat per message byte:
//   data_byte counts only when has_byte is 1; end_of_message closes the message
// - a beat with has_byte 0 and end_of_message 0 does nothing
// - the beat that fills a 64-byte block starts a compression: the rounds,
//   then a fold into the chaining value, all through one shared round unit,
//   with in_stall high meanwhile
// - on end of message the sequencer pads one byte per cycle up to the block
//   end and compresses, once or twice (two when fewer than 9 bytes are left)
// - output channel (out_valid / out_stall) then gives five beats, word 0
//   first, last_word set on word 4; each word holds while out_stall is high
// - sustained rate is set by the round unit, as no byte is taken in a compression
// - after the fifth word is taken the chaining value, fill and length restart
// - reset clears the sequencer and loads the initial chaining value
module sha1_stream_hasher_core
    import sha1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    words5_t     chain_reg, chain_next;
    logic        fin_reg, fin_next;
    logic        pad_reg, pad_next;
    logic        mark_reg, mark_next;
    logic        len_blk_reg, len_blk_next;

    win_ctl_t    win_ctl;
    rnd_ctl_t    rnd_ctl;
    word_t       w_top;
    words5_t     work;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    sha1s_window u_window (
        .clk   (clk),
        .ctl   (win_ctl),
        .w_top (w_top)
    );

    sha1s_round u_round (
        .clk   (clk),
        .ctl   (rnd_ctl),
        .chain (chain_reg),
        .round (round_reg),
        .w     (w_top),
        .work  (work)
    );

    // length bytes go out most significant first at fill 56..63
    assign bit_len  = {count_reg[60:0], 3'b000};
    assign len_byte = bit_len[{~fill_reg[2:0], 3'b000} +: 8];
    assign pad_byte = !mark_reg ? PAD_MARK :
                      (len_blk_reg && fill_reg >= LEN_START) ? len_byte : 8'h00;

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_INDEX);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        round_next   = round_reg;
        idx_next     = idx_reg;
        chain_next   = chain_reg;
        fin_next     = fin_reg;
        pad_next     = pad_reg;
        mark_next    = mark_reg;
        len_blk_next = len_blk_reg;
        win_ctl      = '0;
        rnd_ctl      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        win_ctl.shift_byte = 1'b1;
                        win_ctl.byte_in    = data_byte;
                        fill_next          = fill_reg + 6'd1;
                        count_next         = count_reg + 64'd1;
                        if (fill_reg == LAST_FILL)
                        begin
                            state_next   = ST_ROUND;
                            round_next   = '0;
                            rnd_ctl.load = 1'b1;
                            fin_next     = end_of_message;
                        end
                        else if (end_of_message)
                        begin
                            state_next   = ST_PAD;
                            pad_next     = 1'b1;
                            mark_next    = 1'b0;
                            len_blk_next = (fill_reg < 6'd55);
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next   = ST_PAD;
                        pad_next     = 1'b1;
                        mark_next    = 1'b0;
                        len_blk_next = (fill_reg < LEN_START);
                    end
                end
            end
            ST_ROUND:
            begin
                rnd_ctl.step       = 1'b1;
                win_ctl.shift_word = 1'b1;
                round_next         = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                if (pad_reg)
                begin
                    if (len_blk_reg)
                    begin
                        state_next = ST_EMIT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        state_next   = ST_PAD;
                        len_blk_next = 1'b1;
                    end
                end
                else if (fin_reg)
                begin
                    // block filled by the final byte: padding needs a fresh block
                    state_next   = ST_PAD;
                    pad_next     = 1'b1;
                    mark_next    = 1'b0;
                    len_blk_next = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                win_ctl.shift_byte = 1'b1;
                win_ctl.byte_in    = pad_byte;
                fill_next          = fill_reg + 6'd1;
                mark_next          = 1'b1;
                if (fill_reg == LAST_FILL)
                begin
                    state_next   = ST_ROUND;
                    round_next   = '0;
                    rnd_ctl.load = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_INDEX)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                        chain_next = INIT_CHAIN;
                        fill_next  = '0;
                        count_next = '0;
                        pad_next   = 1'b0;
                        fin_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            count_reg   <= '0;
            round_reg   <= '0;
            idx_reg     <= '0;
            chain_reg   <= INIT_CHAIN;
            fin_reg     <= 1'b0;
            pad_reg     <= 1'b0;
            mark_reg    <= 1'b0;
            len_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            round_reg   <= round_next;
            idx_reg     <= idx_next;
            chain_reg   <= chain_next;
            fin_reg     <= fin_next;
            pad_reg     <= pad_next;
            mark_reg    <= mark_next;
            len_blk_reg <= len_blk_next;
        end
    end

endmodule

FILE: src/sha1s_window.sv
// sha1s_window: 512-bit block buffer that also serves as the rolling message schedule
// bytes shift in during buffering, expanded words shift in during rounds; uses sha1s_pkg
module sha1s_window
    import sha1s_pkg::*;
(
    input  logic     clk,
    input  win_ctl_t ctl,
    output word_t    w_top
);

    logic [511:0] win_reg;
    logic [511:0] win_next;
    word_t        w_new;

    // taps at window positions 0, 2, 8 and 13 give the word sixteen rounds ahead
    assign w_new = rotl1(win_reg[511:480] ^ win_reg[447:416] ^
                         win_reg[255:224] ^ win_reg[95:64]);
    assign w_top = win_reg[511:480];

    always_comb
    begin
        win_next = win_reg;
        if (ctl.shift_byte)
        begin
            win_next = {win_reg[503:0], ctl.byte_in};
        end
        else if (ctl.shift_word)
        begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

FILE: src/sha1s_round.sv
// sha1s_round: working variables a..e and the single shared sha-1 round unit
// one round per step; uses sha1s_pkg
module sha1s_round
    import sha1s_pkg::*;
(
    input  logic       clk,
    input  rnd_ctl_t   ctl,
    input  words5_t    chain,
    input  logic [6:0] round,
    input  word_t      w,
    output words5_t    work
);

    words5_t work_reg;
    words5_t work_next;
    word_t   f;
    word_t   k;
    word_t   tmp;

    always_comb
    begin
        if (round < 7'd20)
        begin
            f = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k = K0;
        end
        else if (round < 7'd40)
        begin
            f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k = K1;
        end
        else if (round < 7'd60)
        begin
            f = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3]) |
                (work_reg[2] & work_reg[3]);
            k = K2;
        end
        else
        begin
            f = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k = K3;
        end
        tmp = rotl5(work_reg[0]) + f + work_reg[4] + k + w;

        work_next = work_reg;
        if (ctl.load)
        begin
            work_next = chain;
        end
        else if (ctl.step)
        begin
            work_next[4] = work_reg[3];
            work_next[3] = work_reg[2];
            work_next[2] = rotl30(work_reg[1]);
            work_next[1] = work_reg[0];
            work_next[0] = tmp;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign work = work_reg;

endmodule

FILE: tb/sha1_stream_hasher_core_tb.sv
`timescale 1ns / 100ps
// sha1_stream_hasher_core_tb: self-checking bench for the byte-stream sha-1 hasher
// a scoreboard class holds its own sha-1 model and checks each digest beat; needs sha1s_pkg
module sha1_stream_hasher_core_tb
    import sha1s_pkg::*;
();

    localparam logic [159:0] SHA1_IV = 160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
    localparam word_t ROUND_K0 = 32'h5a827999;
    localparam word_t ROUND_K1 = 32'h6ed9eba1;
    localparam word_t ROUND_K2 = 32'h8f1bbcdc;
    localparam word_t ROUND_K3 = 32'hca62c1d6;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned TARGET_BEATS = 110;
    localparam int unsigned CALM_FROM = 70;
    localparam int unsigned CALM_LEN = 70;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       is_last;
    } digest_beat_t;

    class sha1_digest_scoreboard;
        word_t        chain [5];
        logic [511:0] block_bytes;
        int unsigned  fill;
        logic [63:0]  byte_count;
        digest_beat_t words_due [$];
        int unsigned  errors;
        int unsigned  digests;
        int unsigned  words_checked;

        function new();
            restart();
            errors = 0;
            digests = 0;
            words_checked = 0;
        endfunction

        function void restart();
            int i;
            for (i = 0; i < 5; i++)
                chain[i] = SHA1_IV[159 - 32 * i -: 32];
            block_bytes = '0;
            fill = 0;
            byte_count = '0;
        endfunction

        function word_t rotate_left(input word_t x, input int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // 80 rounds over one 512-bit block, folded into the chaining value
        function void fold_block(input logic [511:0] blk);
            word_t sched [16];
            word_t a, b, c, d, e, f, k, t;
            int    r;
            for (r = 0; r < 16; r++)
                sched[r] = blk[511 - 32 * r -: 32];
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (r = 0; r < 80; r++)
            begin
                if (r >= 16)
                    sched[r % 16] = rotate_left(sched[(r + 13) % 16] ^ sched[(r + 8) % 16]
                                                ^ sched[(r + 2) % 16] ^ sched[r % 16], 1);
                if (r < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = ROUND_K0;
                end
                else if (r < 40)
                begin
                    f = b ^ c ^ d;
                    k = ROUND_K1;
                end
                else if (r < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = ROUND_K2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = ROUND_K3;
                end
                t = rotate_left(a, 5) + f + e + k + sched[r % 16];
                e = d;
                d = c;
                c = rotate_left(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void absorb_beat(input logic [7:0] d, input logic h, input logic e);
            logic [1023:0] tail;
            logic [63:0]   bit_len;
            int unsigned   nblocks;
            int unsigned   i;
            digest_beat_t  entry;
            if (h)
            begin
                block_bytes[511 - 8 * fill -: 8] = d;
                fill++;
                byte_count++;
                if (fill == 64)
                begin
                    fold_block(block_bytes);
                    fill = 0;
                end
            end
            if (!e)
                return;
            // padding: marker, zeros, 64-bit big-endian bit count
            tail = '0;
            for (i = 0; i < fill; i++)
                tail[1023 - 8 * i -: 8] = block_bytes[511 - 8 * i -: 8];
            tail[1023 - 8 * fill -: 8] = PAD_BYTE;
            nblocks = (fill + 9 <= 64) ? 1 : 2;
            bit_len = byte_count << 3;
            tail[1023 - 8 * (64 * nblocks - 8) -: 64] = bit_len;
            fold_block(tail[1023:512]);
            if (nblocks == 2)
                fold_block(tail[511:0]);
            for (i = 0; i < 5; i++)
            begin
                entry.word = chain[i];
                entry.index = i[2:0];
                entry.is_last = (i == 4);
                words_due.push_back(entry);
            end
            digests++;
            restart();
        endfunction

        function void check_word(input word_t word, input logic [2:0] index,
                                 input logic is_last);
            digest_beat_t want;
            words_checked++;
            if (words_due.size() == 0)
            begin
                $error("digest beat with nothing due: digest_word %h", word);
                errors++;
                return;
            end
            want = words_due.pop_front();
            if (word !== want.word)
            begin
                $error("digest_word: expected %h, got %h", want.word, word);
                errors++;
            end
            if (index !== want.index)
            begin
                $error("word_index: expected %0d, got %0d", want.index, index);
                errors++;
            end
            if (is_last !== want.is_last)
            begin
                $error("last_word: expected %0d, got %0d", want.is_last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha1_digest_scoreboard sb;
    bit          calm = 1'b0;
    int unsigned beats_sent = 0;
    int unsigned cycle_count = 0;

    sha1_stream_hasher_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver side: random stall except during the calm stretch
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !calm && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(digest_word, word_index, last_word);
    end

    task automatic send_beat(input logic [7:0] d, input logic h, input logic e);
        calm = (beats_sent >= CALM_FROM) && (beats_sent < CALM_FROM + CALM_LEN);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        has_byte <= h;
        end_of_message <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.absorb_beat(d, h, e);
        if (h || e)
            beats_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        bit          split_end;
        int unsigned i;
        split_end = (len == 0) || ($urandom_range(0, 2) == 0);
        for (i = 0; i < len; i++)
        begin
            // occasional empty beat that the block should ignore
            if ($urandom_range(0, 11) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split_end);
        end
        if (split_end)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // sender goes idle so the last beat is not taken twice
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.words_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned n_msg;
        int unsigned n_long;
        int unsigned len;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        has_byte = 1'b0;
        end_of_message = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_beat(8'hff, 1'b0, 1'b0);
        // empty message, data byte must be ignored
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b1);
        send_beat(8'h80, 1'b1, 1'b1);
        send_beat(8'h7f, 1'b1, 1'b0);
        send_beat(8'h01, 1'b0, 1'b1);
        // hold off until every digest has drained
        wait_drained();

        n_msg = 0;
        n_long = 0;
        while (beats_sent < TARGET_BEATS || n_long < 2)
        begin
            // long messages hit two-block pad and a full block
            if (n_msg % 2 == 1 && n_long < 2)
            begin
                case (n_long)
                    0: len = 56;
                    default: len = 64;
                endcase
                n_long++;
            end
            else
                len = $urandom_range(0, 9);
            send_message(len);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            n_msg++;
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.words_due.size() != 0)
            $error("%0d digest words never arrived", sb.words_due.size());
        $display("covered %0d beats in %0d messages, %0d digest words checked",
                 beats_sent, sb.digests, sb.words_checked);
        $display("incl. empty message, split end beats, one- and two-block padding");
        if (sb.errors == 0 && sb.words_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/sha1s_pkg.sv
src/sha1s_window.sv
src/sha1s_round.sv
src/sha1_stream_hasher_core.sv
tb/sha1_stream_hasher_core_tb.sv
